// ----- rtl/core/pwc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and reset values of the power window controller.
package pwc_pkg;

  localparam int unsigned IdW      = 11;
  localparam int unsigned ThrW     = 8;
  localparam int unsigned CurW     = 12;
  localparam int unsigned TickW    = 10;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned CmdW     = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  localparam logic [HoldW-1:0] HoldMax = '1;

  // Reset values; current limit is 12 A on a 40 A full scale of 4095 counts
  localparam logic [IdW-1:0]   OwnIdRst    = 11'd2;
  localparam logic [ThrW-1:0]  HoldThrRst  = 8'd15;
  localparam logic [CurW-1:0]  CurLimitRst = 12'd1228;
  localparam logic [TickW-1:0] ConfirmRst  = 10'd200;
  localparam logic [TickW-1:0] HoldoffRst  = 10'd400;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    PH_NORMAL  = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_HOLDOFF = 2'd2
  } phase_e;

  typedef enum logic [CmdW-1:0] {
    WIN_STOP   = 8'd20,
    WIN_UP     = 8'd21,
    WIN_DOWN   = 8'd22,
    WIN_AUTO   = 8'd23,
    WIN_LOCK   = 8'd25,
    WIN_UNLOCK = 8'd26
  } glass_cmd_e;

  typedef enum logic [CmdW-1:0] {
    MIR_OFF = 8'd20,
    MIR_ON  = 8'd21
  } mirror_cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OWN_ID    = 3'd0,
    CFG_HOLD_THR  = 3'd1,
    CFG_CUR_LIMIT = 3'd2,
    CFG_CONFIRM   = 3'd3,
    CFG_HOLDOFF   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic             action;
    logic             up_pressed;
    logic             down_pressed;
    logic [CurW-1:0]  motor_current;
    logic [IdW-1:0]   frame_id;
    logic [CmdW-1:0]  glass_cmd;
    logic [CmdW-1:0]  mirror_cmd;
  } in_t;

  typedef struct packed {
    logic drive_up;
    logic drive_down;
    logic mirror_heater;
    logic window_locked;
    logic close_done;
  } out_t;

  typedef struct packed {
    logic [IdW-1:0]   own_id;
    logic [ThrW-1:0]  hold_threshold;
    logic [CurW-1:0]  current_limit;
    logic [TickW-1:0] confirm_ticks;
    logic [TickW-1:0] holdoff_ticks;
  } cfg_t;

endpackage

// ----- rtl/core/pwc_cfg.sv -----
`timescale 1ns / 1ps
// Configuration register bank of the power window controller.
module pwc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pwc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pwc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output pwc_pkg::cfg_t                  cfg_o
);

  pwc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pwc_pkg::CFG_OWN_ID:    cfg_d.own_id         = cfg_wdata_i[pwc_pkg::IdW-1:0];
        pwc_pkg::CFG_HOLD_THR:  cfg_d.hold_threshold = cfg_wdata_i[pwc_pkg::ThrW-1:0];
        pwc_pkg::CFG_CUR_LIMIT: cfg_d.current_limit  = cfg_wdata_i[pwc_pkg::CurW-1:0];
        pwc_pkg::CFG_CONFIRM:   cfg_d.confirm_ticks  = cfg_wdata_i[pwc_pkg::TickW-1:0];
        pwc_pkg::CFG_HOLDOFF:   cfg_d.holdoff_ticks  = cfg_wdata_i[pwc_pkg::TickW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_id         <= pwc_pkg::OwnIdRst;
      cfg_q.hold_threshold <= pwc_pkg::HoldThrRst;
      cfg_q.current_limit  <= pwc_pkg::CurLimitRst;
      cfg_q.confirm_ticks  <= pwc_pkg::ConfirmRst;
      cfg_q.holdoff_ticks  <= pwc_pkg::HoldoffRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/pwc_ctrl.sv -----
`timescale 1ns / 1ps
// Window state, button, guard and command update logic.
module pwc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_en_i,
  input  pwc_pkg::in_t   item_i,
  input  pwc_pkg::cfg_t  cfg_i,
  output pwc_pkg::out_t  res_o
);

  pwc_pkg::dir_e               dir_q, dir_d;
  pwc_pkg::phase_e             phase_q, phase_d;
  logic [pwc_pkg::HoldW-1:0]   hold_q, hold_d;
  logic [pwc_pkg::TickW-1:0]   gcnt_q, gcnt_d;
  logic                        locked_q, locked_d;
  logic                        auto_q, auto_d;
  logic                        heater_q, heater_d;
  logic                        done;
  logic                        over;

  assign over = item_i.motor_current > cfg_i.current_limit;

  always_comb begin
    dir_d    = dir_q;
    phase_d  = phase_q;
    hold_d   = hold_q;
    gcnt_d   = gcnt_q;
    locked_d = locked_q;
    auto_d   = auto_q;
    heater_d = heater_q;
    done     = 1'b0;

    if (!item_i.action) begin
      unique case (phase_q)
        pwc_pkg::PH_CONFIRM: begin
          if (gcnt_q <= pwc_pkg::TickW'(1)) begin
            gcnt_d  = '0;
            phase_d = pwc_pkg::PH_NORMAL;
            if (over) begin
              dir_d = pwc_pkg::DIR_STOP;
              if (auto_q) begin
                done   = 1'b1;
                auto_d = 1'b0;
              end
              if (cfg_i.holdoff_ticks != '0) begin
                phase_d = pwc_pkg::PH_HOLDOFF;
                gcnt_d  = cfg_i.holdoff_ticks;
              end
            end
          end else begin
            gcnt_d = gcnt_q - pwc_pkg::TickW'(1);
          end
        end
        pwc_pkg::PH_HOLDOFF: begin
          if (gcnt_q <= pwc_pkg::TickW'(1)) begin
            gcnt_d  = '0;
            phase_d = pwc_pkg::PH_NORMAL;
          end else begin
            gcnt_d = gcnt_q - pwc_pkg::TickW'(1);
          end
        end
        default: begin
          phase_d = pwc_pkg::PH_NORMAL;
          if (!locked_q && !auto_q) begin
            // raise button first, then lower button on the same tick
            if (item_i.up_pressed) begin
              if (dir_d == pwc_pkg::DIR_STOP) begin
                hold_d = '0;
                dir_d  = pwc_pkg::DIR_UP;
              end
              if (hold_d != pwc_pkg::HoldMax) hold_d = hold_d + pwc_pkg::HoldW'(1);
            end else if (dir_d == pwc_pkg::DIR_UP &&
                         hold_d > pwc_pkg::HoldW'(cfg_i.hold_threshold)) begin
              dir_d = pwc_pkg::DIR_STOP;
            end
            if (item_i.down_pressed) begin
              if (dir_d == pwc_pkg::DIR_STOP) begin
                hold_d = '0;
                dir_d  = pwc_pkg::DIR_DOWN;
              end
              if (hold_d != pwc_pkg::HoldMax) hold_d = hold_d + pwc_pkg::HoldW'(1);
            end else if (dir_d == pwc_pkg::DIR_DOWN &&
                         hold_d > pwc_pkg::HoldW'(cfg_i.hold_threshold)) begin
              dir_d = pwc_pkg::DIR_STOP;
            end
          end
          if (dir_d != pwc_pkg::DIR_STOP && over) begin
            phase_d = pwc_pkg::PH_CONFIRM;
            gcnt_d  = cfg_i.confirm_ticks;
          end
        end
      endcase
    end else if (item_i.frame_id == cfg_i.own_id) begin
      unique case (item_i.glass_cmd)
        pwc_pkg::WIN_STOP: dir_d = pwc_pkg::DIR_STOP;
        pwc_pkg::WIN_UP:   dir_d = pwc_pkg::DIR_UP;
        pwc_pkg::WIN_DOWN: dir_d = pwc_pkg::DIR_DOWN;
        pwc_pkg::WIN_AUTO: begin
          auto_d = 1'b1;
          dir_d  = pwc_pkg::DIR_UP;
        end
        pwc_pkg::WIN_LOCK: begin
          locked_d = 1'b1;
          dir_d    = pwc_pkg::DIR_STOP;
        end
        pwc_pkg::WIN_UNLOCK: locked_d = 1'b0;
        default: ;
      endcase
      unique case (item_i.mirror_cmd)
        pwc_pkg::MIR_OFF: heater_d = 1'b0;
        pwc_pkg::MIR_ON:  heater_d = 1'b1;
        default: ;
      endcase
    end
  end

  assign res_o.drive_up      = dir_d == pwc_pkg::DIR_UP;
  assign res_o.drive_down    = dir_d == pwc_pkg::DIR_DOWN;
  assign res_o.mirror_heater = heater_d;
  assign res_o.window_locked = locked_d;
  assign res_o.close_done    = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q    <= pwc_pkg::DIR_STOP;
      phase_q  <= pwc_pkg::PH_NORMAL;
      hold_q   <= '0;
      gcnt_q   <= '0;
      locked_q <= 1'b0;
      auto_q   <= 1'b0;
      heater_q <= 1'b0;
    end else if (item_en_i) begin
      dir_q    <= dir_d;
      phase_q  <= phase_d;
      hold_q   <= hold_d;
      gcnt_q   <= gcnt_d;
      locked_q <= locked_d;
      auto_q   <= auto_d;
      heater_q <= heater_d;
    end
  end

  a_done_clears_auto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_en_i && res_o.close_done |=> !auto_q)
    else $error("auto-close still pending after done notice");

  a_holdoff_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == pwc_pkg::PH_HOLDOFF |-> gcnt_q != '0)
    else $error("holdoff phase with empty counter");

  a_locked_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_en_i && locked_q |=> $stable(hold_q))
    else $error("hold counter moved while locked");

endmodule

// ----- rtl/core/power_window_controller.sv -----
`timescale 1ns / 1ps
// Top level of the power window controller: input and result registers around the update.
// Path from input transfer to result: the input register, the update logic, the result register.
// Throughput: one item per cycle while results are taken; all state updates in one pass.
// A result waiting in the result register lets the input register take one more item only.
// Reset (rst_ni low, asynchronous): motor stopped, unlocked, no auto-close, heater off,
// guard idle, pipeline empty, configuration at its defaults.
module power_window_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pwc_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pwc_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [pwc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pwc_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  pwc_pkg::in_t   in_q;
  logic           in_vld_q;
  pwc_pkg::out_t  out_q, res;
  logic           out_vld_q;
  pwc_pkg::cfg_t  cfg;
  logic           advance;

  // item moves on when the result register is free or being emptied
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  pwc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pwc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_en_i (advance),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- test/tb_power_window_controller.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the power window controller: directed and random items.
module tb_power_window_controller;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 4;
  localparam int MaxReports = 10;
  localparam int InBits = $bits(pwc_pkg::in_t);
  localparam logic [pwc_pkg::CmdW-1:0] WIN_UNKNOWN = 8'd24;
  localparam logic [pwc_pkg::CmdW-1:0] MIR_UNKNOWN = 8'd22;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pwc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pwc_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [pwc_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [pwc_pkg::CfgDataW-1:0] cfg_wdata = '0;

  power_window_controller u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  pwc_pkg::in_t  pending_items[$];
  pwc_pkg::out_t expected_states[$];
  int   idle_pct = 26;
  logic in_taken = 1'b0;
  int   n_fail = 0;
  int   cycle_cnt = 0;
  logic [1:0] btn_level = 2'b00;

  // Shadow copy of the controller state and registers
  pwc_pkg::cfg_t cfg_sh = '{pwc_pkg::OwnIdRst, pwc_pkg::HoldThrRst, pwc_pkg::CurLimitRst,
                            pwc_pkg::ConfirmRst, pwc_pkg::HoldoffRst};
  pwc_pkg::dir_e             win_dir = pwc_pkg::DIR_STOP;
  logic [pwc_pkg::HoldW-1:0] hold_cnt = '0;
  logic                      win_locked = 1'b0;
  logic                      auto_close = 1'b0;
  logic                      heater = 1'b0;
  pwc_pkg::phase_e           guard_ph = pwc_pkg::PH_NORMAL;
  logic [pwc_pkg::TickW-1:0] guard_cnt = '0;

  function automatic void press_btn(pwc_pkg::dir_e d);
    if (win_dir == pwc_pkg::DIR_STOP) begin
      hold_cnt = '0;
      win_dir = d;
    end
    if (hold_cnt != pwc_pkg::HoldMax) hold_cnt = hold_cnt + 1'b1;
  endfunction

  function automatic void release_btn(pwc_pkg::dir_e d);
    if (win_dir == d && hold_cnt > pwc_pkg::HoldW'(cfg_sh.hold_threshold))
      win_dir = pwc_pkg::DIR_STOP;
  endfunction

  function automatic pwc_pkg::out_t window_next(pwc_pkg::in_t it);
    pwc_pkg::out_t r;
    logic done;
    logic over;
    done = 1'b0;
    over = it.motor_current > cfg_sh.current_limit;
    if (!it.action) begin
      if (guard_ph == pwc_pkg::PH_CONFIRM) begin
        // second look at the current once the confirm wait runs out
        if (guard_cnt <= 1) begin
          guard_cnt = '0;
          guard_ph = pwc_pkg::PH_NORMAL;
          if (over) begin
            win_dir = pwc_pkg::DIR_STOP;
            if (auto_close) begin
              done = 1'b1;
              auto_close = 1'b0;
            end
            if (cfg_sh.holdoff_ticks != 0) begin
              guard_ph = pwc_pkg::PH_HOLDOFF;
              guard_cnt = cfg_sh.holdoff_ticks;
            end
          end
        end else begin
          guard_cnt = guard_cnt - 1'b1;
        end
      end else if (guard_ph == pwc_pkg::PH_HOLDOFF) begin
        if (guard_cnt <= 1) begin
          guard_cnt = '0;
          guard_ph = pwc_pkg::PH_NORMAL;
        end else begin
          guard_cnt = guard_cnt - 1'b1;
        end
      end else begin
        if (!win_locked && !auto_close) begin
          if (it.up_pressed) press_btn(pwc_pkg::DIR_UP);
          else release_btn(pwc_pkg::DIR_UP);
          if (it.down_pressed) press_btn(pwc_pkg::DIR_DOWN);
          else release_btn(pwc_pkg::DIR_DOWN);
        end
        if (win_dir != pwc_pkg::DIR_STOP && over) begin
          guard_ph = pwc_pkg::PH_CONFIRM;
          guard_cnt = cfg_sh.confirm_ticks;
        end
      end
    end else if (it.frame_id == cfg_sh.own_id) begin
      case (it.glass_cmd)
        pwc_pkg::WIN_STOP: win_dir = pwc_pkg::DIR_STOP;
        pwc_pkg::WIN_UP:   win_dir = pwc_pkg::DIR_UP;
        pwc_pkg::WIN_DOWN: win_dir = pwc_pkg::DIR_DOWN;
        pwc_pkg::WIN_AUTO: begin
          auto_close = 1'b1;
          win_dir = pwc_pkg::DIR_UP;
        end
        pwc_pkg::WIN_LOCK: begin
          win_locked = 1'b1;
          win_dir = pwc_pkg::DIR_STOP;
        end
        pwc_pkg::WIN_UNLOCK: win_locked = 1'b0;
        default: ;
      endcase
      if (it.mirror_cmd == pwc_pkg::MIR_OFF) heater = 1'b0;
      else if (it.mirror_cmd == pwc_pkg::MIR_ON) heater = 1'b1;
    end
    r.drive_up = (win_dir == pwc_pkg::DIR_UP);
    r.drive_down = (win_dir == pwc_pkg::DIR_DOWN);
    r.mirror_heater = heater;
    r.window_locked = win_locked;
    r.close_done = done;
    return r;
  endfunction

  function automatic pwc_pkg::in_t tick_item(logic up, logic down,
                                             logic [pwc_pkg::CurW-1:0] cur);
    pwc_pkg::in_t it;
    it = '0;
    it.up_pressed = up;
    it.down_pressed = down;
    it.motor_current = cur;
    return it;
  endfunction

  function automatic pwc_pkg::in_t frame_item(logic [pwc_pkg::IdW-1:0] id,
                                              logic [pwc_pkg::CmdW-1:0] glass,
                                              logic [pwc_pkg::CmdW-1:0] mirror);
    pwc_pkg::in_t it;
    it = '0;
    it.action = 1'b1;
    it.frame_id = id;
    it.glass_cmd = glass;
    it.mirror_cmd = mirror;
    return it;
  endfunction

  // Mostly ticks with buttons held over runs of ticks; fields a kind ignores stay random
  function automatic pwc_pkg::in_t random_item();
    pwc_pkg::in_t it;
    int pick;
    logic [pwc_pkg::CmdW-1:0] glass_codes [6];
    glass_codes = '{pwc_pkg::WIN_STOP, pwc_pkg::WIN_UP, pwc_pkg::WIN_DOWN,
                    pwc_pkg::WIN_AUTO, pwc_pkg::WIN_LOCK, pwc_pkg::WIN_UNLOCK};
    it = pwc_pkg::in_t'(InBits'({$urandom, $urandom}));
    if ($urandom_range(0, 99) < 75) begin
      it.action = 1'b0;
      if ($urandom_range(0, 99) < 25) btn_level = 2'($urandom);
      it.up_pressed = btn_level[1];
      it.down_pressed = btn_level[0];
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        it.motor_current = pwc_pkg::CurW'($urandom_range(0, cfg_sh.current_limit));
      end else if (pick < 90) begin
        if (cfg_sh.current_limit == '1) it.motor_current = '1;
        else it.motor_current =
            pwc_pkg::CurW'($urandom_range(cfg_sh.current_limit + 1, 4095));
      end
    end else begin
      it.action = 1'b1;
      if ($urandom_range(0, 99) < 85) it.frame_id = cfg_sh.own_id;
      if ($urandom_range(0, 99) < 80) it.glass_cmd = glass_codes[$urandom_range(0, 5)];
      pick = $urandom_range(0, 99);
      if (pick < 40) it.mirror_cmd = pwc_pkg::MIR_OFF;
      else if (pick < 80) it.mirror_cmd = pwc_pkg::MIR_ON;
    end
    return it;
  endfunction

  task automatic write_reg(input pwc_pkg::cfg_idx_e idx,
                           input logic [pwc_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      pwc_pkg::CFG_OWN_ID:    cfg_sh.own_id = val[pwc_pkg::IdW-1:0];
      pwc_pkg::CFG_HOLD_THR:  cfg_sh.hold_threshold = val[pwc_pkg::ThrW-1:0];
      pwc_pkg::CFG_CUR_LIMIT: cfg_sh.current_limit = val[pwc_pkg::CurW-1:0];
      pwc_pkg::CFG_CONFIRM:   cfg_sh.confirm_ticks = val[pwc_pkg::TickW-1:0];
      pwc_pkg::CFG_HOLDOFF:   cfg_sh.holdoff_ticks = val[pwc_pkg::TickW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input pwc_pkg::cfg_t c);
    write_reg(pwc_pkg::CFG_OWN_ID, pwc_pkg::CfgDataW'(c.own_id));
    write_reg(pwc_pkg::CFG_HOLD_THR, pwc_pkg::CfgDataW'(c.hold_threshold));
    write_reg(pwc_pkg::CFG_CUR_LIMIT, pwc_pkg::CfgDataW'(c.current_limit));
    write_reg(pwc_pkg::CFG_CONFIRM, pwc_pkg::CfgDataW'(c.confirm_ticks));
    write_reg(pwc_pkg::CFG_HOLDOFF, pwc_pkg::CfgDataW'(c.holdoff_ticks));
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_states.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_random(input int n);
    repeat (n) pending_items.push_back(random_item());
    wait_idle();
  endtask

  // Driver: inputs move on the falling edge only
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
      if (!in_valid || in_taken) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on each input transfer, check on each result transfer
  always @(posedge clk_i) begin
    pwc_pkg::out_t want;
    in_taken <= in_valid && in_ready;
    if (rst_ni && in_valid && in_ready) expected_states.push_back(window_next(in_data));
    if (rst_ni && out_valid && out_ready) begin
      if (expected_states.size() == 0) begin
        n_fail++;
        if (n_fail <= MaxReports)
          $display("unexpected result: up=%0b dn=%0b heat=%0b lock=%0b done=%0b",
                   out_data.drive_up, out_data.drive_down, out_data.mirror_heater,
                   out_data.window_locked, out_data.close_done);
      end else begin
        want = expected_states.pop_front();
        if (out_data.drive_up !== want.drive_up || out_data.drive_down !== want.drive_down ||
            out_data.mirror_heater !== want.mirror_heater ||
            out_data.window_locked !== want.window_locked ||
            out_data.close_done !== want.close_done) begin
          n_fail++;
          if (n_fail <= MaxReports)
            $display("mismatch exp up/dn/heat/lock/done=%0b%0b%0b%0b%0b got %0b%0b%0b%0b%0b",
                     want.drive_up, want.drive_down, want.mirror_heater, want.window_locked,
                     want.close_done, out_data.drive_up, out_data.drive_down,
                     out_data.mirror_heater, out_data.window_locked, out_data.close_done);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    pwc_pkg::cfg_t rnd;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short guard times so the whole overcurrent path fits in a few items
    load_setting('{11'd2047, 8'd2, 12'd100, 10'd1, 10'd1});
    pending_items.push_back(frame_item(11'd2047, pwc_pkg::WIN_UNLOCK, pwc_pkg::MIR_ON));
    pending_items.push_back(tick_item(1'b1, 1'b0, 12'd0));
    pending_items.push_back(tick_item(1'b0, 1'b0, 12'd0));     // short tap keeps travelling
    pending_items.push_back(frame_item(11'd2047, pwc_pkg::WIN_STOP, pwc_pkg::MIR_OFF));
    repeat (3) pending_items.push_back(tick_item(1'b1, 1'b0, 12'd0));
    pending_items.push_back(tick_item(1'b0, 1'b0, 12'd0));     // long hold released
    pending_items.push_back(tick_item(1'b1, 1'b1, 12'd4095));  // both buttons, overcurrent
    pending_items.push_back(tick_item(1'b0, 1'b0, 12'd4095));  // confirmed, stop
    pending_items.push_back(tick_item(1'b0, 1'b1, 12'd0));     // holdoff
    pending_items.push_back(tick_item(1'b0, 1'b1, 12'd0));
    pending_items.push_back(frame_item(11'd2047, pwc_pkg::WIN_AUTO, 8'd0));
    pending_items.push_back(tick_item(1'b0, 1'b1, 12'd101));
    pending_items.push_back(tick_item(1'b0, 1'b0, 12'd4095));  // auto-close ends
    pending_items.push_back(tick_item(1'b0, 1'b0, 12'd0));
    pending_items.push_back(frame_item(11'd2047, pwc_pkg::WIN_LOCK, 8'd255));
    pending_items.push_back(tick_item(1'b1, 1'b0, 12'd0));     // locked out
    pending_items.push_back(frame_item(11'd0, pwc_pkg::WIN_UNLOCK, pwc_pkg::MIR_ON));
    pending_items.push_back(frame_item(11'd2047, pwc_pkg::WIN_DOWN, MIR_UNKNOWN));
    pending_items.push_back(tick_item(1'b0, 1'b0, 12'd100));   // at the limit, not over
    pending_items.push_back(frame_item(11'd2047, WIN_UNKNOWN, pwc_pkg::MIR_OFF));
    pending_items.push_back(frame_item(11'd2047, pwc_pkg::WIN_UNLOCK, pwc_pkg::MIR_OFF));
    pending_items.push_back(frame_item(11'd2047, pwc_pkg::WIN_UP, 8'd0));
    pending_items.push_back(tick_item(1'b0, 1'b0, 12'd4095));
    pending_items.push_back(tick_item(1'b1, 1'b0, 12'd0));     // second look finds it clear
    pending_items.push_back(tick_item(1'b1, 1'b0, 12'd0));
    wait_idle();

    load_setting('{pwc_pkg::OwnIdRst, pwc_pkg::HoldThrRst, pwc_pkg::CurLimitRst,
                   pwc_pkg::ConfirmRst, pwc_pkg::HoldoffRst});
    run_random(300);

    // zero confirm behaves as one, zero holdoff skips it
    idle_pct = 0;
    load_setting('{11'd0, 8'd0, 12'd0, 10'd0, 10'd0});
    run_random(350);
    idle_pct = 26;

    load_setting('{11'd2047, 8'd255, 12'd4094, 10'd1023, 10'd1023});
    run_random(300);

    load_setting('{11'd5, 8'd1, 12'd4095, 10'd1, 10'd0});
    run_random(100);

    repeat (3) begin
      rnd.own_id = pwc_pkg::IdW'($urandom);
      rnd.hold_threshold = pwc_pkg::ThrW'($urandom_range(0, 20));
      rnd.current_limit = pwc_pkg::CurW'($urandom);
      rnd.confirm_ticks = pwc_pkg::TickW'($urandom_range(1, 12));
      rnd.holdoff_ticks = pwc_pkg::TickW'($urandom_range(0, 12));
      load_setting(rnd);
      run_random(300);
    end

    if (n_fail == 0 && expected_states.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pwc_pkg.sv
rtl/core/pwc_cfg.sv
rtl/core/pwc_ctrl.sv
rtl/core/power_window_controller.sv
test/tb_power_window_controller.sv
